>>> rtl/wlss_pkg.sv
// Shared types and constants for the work-group local size selector.
package wlss_pkg;

    localparam int unsigned DIV_W   = 24;
    localparam int unsigned LOC_W   = 11;
    localparam int unsigned CU_W    = 9;
    localparam int unsigned SG_W    = 8;
    localparam int unsigned MODEL_W = 10;
    localparam int unsigned M_W     = 10;
    localparam int unsigned PROD_W  = 2 * LOC_W;

    localparam logic [MODEL_W-1:0] C_MODEL_DOUBLING = 10'd540;

    typedef enum logic [1:0] {
        CFG_CU_COUNT       = 2'd0,
        CFG_MAX_GROUP_SIZE = 2'd1,
        CFG_SUBGROUP_WIDTH = 2'd2,
        CFG_GPU_MODEL      = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [CU_W-1:0]    cu_count;
        logic [LOC_W-1:0]   max_group_size;
        logic [SG_W-1:0]    subgroup_width;
        logic [MODEL_W-1:0] gpu_model;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PASS,
        S_WAIT_M,
        S_WAIT_MAXV,
        S_WAIT_MINV,
        S_CAND,
        S_WAIT_AB,
        S_WAIT_G0,
        S_WAIT_G1,
        S_REJECT,
        S_WAIT_LA,
        S_WAIT_MODA,
        S_FIN
    } t_state;

endpackage

>>> rtl/workgroup_local_size_select.sv
// Top level of the work-group local size selector.
// Usage:
//   Config channel (i_cfg_valid / o_cfg_ready, index + data) writes compute
//   units, max group size, subgroup width and GPU model. Always ready; write
//   only while no request transaction is outstanding.
//   Request channel (i_in_valid / o_in_ready) takes one 2D or 3D global size.
//   Ready is high only while the sequencer is idle: one request at a time.
//   Result channel (o_out_valid / i_out_ready) returns one transaction per
//   request: found flag plus three local sizes.
// Search: every step runs on one shared divider, and a search makes two
//   passes at most, plus the steps of the first-size countdown in 3D.
//   Candidates range up to max_group_size; with max_group_size of 0 the
//   sequencer skips the search and goes from idle straight to its finish.
// Reset: registers return to 1, 256, 0, 0; the sequencer goes idle and the
//   result register empties.
// Stall: a finished result waits in the sequencer until the output register
//   is free, then the next request may be taken while the result is held.
module workgroup_local_size_select (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [wlss_pkg::LOC_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  logic [wlss_pkg::DIV_W-1:0]     i_size_a,
    input  logic [wlss_pkg::DIV_W-1:0]     i_size_b,
    input  logic [wlss_pkg::DIV_W-1:0]     i_size_c,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_found,
    output logic [wlss_pkg::LOC_W-1:0]     o_local_a,
    output logic [wlss_pkg::LOC_W-1:0]     o_local_b,
    output logic [wlss_pkg::LOC_W-1:0]     o_local_c
);
    import wlss_pkg::*;

    t_cfg             r_cfg;
    t_div_req         w_div_req;
    t_div_rsp         w_div_rsp;
    logic             w_idle, w_fin, w_take, w_start;
    logic             w_found;
    logic [LOC_W-1:0] w_la, w_lb, w_lc;
    logic             r_ovalid;
    logic             r_found;
    logic [LOC_W-1:0] r_la, r_lb, r_lc;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cu_count       <= CU_W'(1);
            r_cfg.max_group_size <= LOC_W'(256);
            r_cfg.subgroup_width <= '0;
            r_cfg.gpu_model      <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_CU_COUNT:       r_cfg.cu_count       <= i_cfg_data[CU_W-1:0];
                CFG_MAX_GROUP_SIZE: r_cfg.max_group_size <= i_cfg_data;
                CFG_SUBGROUP_WIDTH: r_cfg.subgroup_width <= i_cfg_data[SG_W-1:0];
                CFG_GPU_MODEL:      r_cfg.gpu_model      <= i_cfg_data[MODEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = w_idle;
    assign w_start    = i_in_valid && w_idle;
    // hand the result over once the output register is empty or draining
    assign w_take     = w_fin && (!r_ovalid || i_out_ready);

    wlss_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_start    (w_start),
        .i_req_type (i_req_type),
        .i_size_a   (i_size_a),
        .i_size_b   (i_size_b),
        .i_size_c   (i_size_c),
        .o_idle     (w_idle),
        .o_fin      (w_fin),
        .i_take     (w_take),
        .o_found    (w_found),
        .o_local_a  (w_la),
        .o_local_b  (w_lb),
        .o_local_c  (w_lc),
        .o_div_req  (w_div_req),
        .i_div_rsp  (w_div_rsp)
    );

    wlss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_take) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
        if (w_take) begin
            r_found <= w_found;
            r_la    <= w_la;
            r_lb    <= w_lb;
            r_lc    <= w_lc;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_found     = r_found;
    assign o_local_a   = r_la;
    assign o_local_b   = r_lb;
    assign o_local_c   = r_lc;

endmodule

>>> rtl/wlss_div.sv
// Restoring divider, one quotient bit per cycle, shared by all steps of the search.
module wlss_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wlss_pkg::t_div_req i_req,
    output wlss_pkg::t_div_rsp o_rsp
);
    import wlss_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_dvs, n_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DIV_W:0]   w_shift;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_cnt  = CNT_W'(DIV_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_ge ? DIV_W'(w_shift - {1'b0, r_dvs}) : w_shift[DIV_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

>>> rtl/wlss_seq.sv
// Sequencer and datapath registers of the local size search.
module wlss_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  wlss_pkg::t_cfg             i_cfg,
    input  logic                       i_start,
    input  logic                       i_req_type,
    input  logic [wlss_pkg::DIV_W-1:0] i_size_a,
    input  logic [wlss_pkg::DIV_W-1:0] i_size_b,
    input  logic [wlss_pkg::DIV_W-1:0] i_size_c,
    output logic                       o_idle,
    output logic                       o_fin,
    input  logic                       i_take,
    output logic                       o_found,
    output logic [wlss_pkg::LOC_W-1:0] o_local_a,
    output logic [wlss_pkg::LOC_W-1:0] o_local_b,
    output logic [wlss_pkg::LOC_W-1:0] o_local_c,
    output wlss_pkg::t_div_req         o_div_req,
    input  wlss_pkg::t_div_rsp         i_div_rsp
);
    import wlss_pkg::*;

    t_state           r_state, n_state;
    logic             r_three, n_three;
    logic [DIV_W-1:0] r_ga, n_ga, r_g0, n_g0, r_g1, n_g1;
    logic             r_fix, n_fix, r_fb, n_fb;
    logic [M_W-1:0]   r_m, n_m;
    logic [LOC_W-1:0] r_lf, n_lf, r_ls, n_ls, r_maxv, n_maxv, r_minv, n_minv;
    logic [LOC_W-1:0] r_la, n_la, r_lb, n_lb, r_lc, n_lc;
    logic             r_found, n_found;

    logic [DIV_W-1:0]  w_gf, w_gs, w_q;
    logic              w_rem0, w_done;
    logic [LOC_W-1:0]  w_lf_new, w_q1, w_a, w_b, w_fb_ls, w_fb_ls_new;
    logic              w_ord_ok;
    logic [PROD_W-1:0] w_prod;
    logic [CU_W-1:0]   w_cu;

    // min(gs, lim), at least 1
    function automatic logic [LOC_W-1:0] cap1(input logic [DIV_W-1:0] gs,
                                              input logic [LOC_W-1:0] lim);
        logic [LOC_W-1:0] v;
        v = (gs > DIV_W'(lim)) ? lim : gs[LOC_W-1:0];
        return (v == '0) ? LOC_W'(1) : v;
    endfunction

    assign w_gf     = r_fix ? r_g1 : r_g0;
    assign w_gs     = r_fix ? r_g0 : r_g1;
    assign w_q      = i_div_rsp.quo;
    assign w_rem0   = (i_div_rsp.rem == '0);
    assign w_done   = i_div_rsp.done;
    assign w_lf_new = (w_q > DIV_W'(i_cfg.max_group_size)) ? i_cfg.max_group_size
                                                           : w_q[LOC_W-1:0];
    assign w_q1     = (w_q == '0) ? LOC_W'(1) : w_q[LOC_W-1:0];
    assign w_a      = r_fix ? r_ls : r_lf;
    assign w_b      = r_fix ? r_lf : r_ls;
    assign w_ord_ok = ((w_a < w_b) == (r_g0 < r_g1));
    assign w_prod   = PROD_W'(w_a) * PROD_W'(w_b);
    assign w_fb_ls     = cap1(w_gs, r_maxv);
    assign w_fb_ls_new = cap1(w_gs, w_q1);
    assign w_cu     = (i_cfg.cu_count == '0) ? CU_W'(1) : i_cfg.cu_count;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:
                if (i_start) begin
                    n_state = (i_cfg.max_group_size == '0) ? S_FIN : S_PASS;
                end
            S_PASS:      n_state = S_WAIT_M;
            S_WAIT_M:
                if (w_done) begin
                    if (!w_rem0 || w_lf_new == '0) begin
                        n_state = r_fix ? S_PASS : S_FIN;
                    end else begin
                        n_state = S_WAIT_MAXV;
                    end
                end
            S_WAIT_MAXV:
                if (w_done) begin
                    n_state = (i_cfg.subgroup_width != '0) ? S_WAIT_MINV : S_CAND;
                end
            S_WAIT_MINV:
                if (w_done) begin
                    n_state = S_CAND;
                end
            S_CAND:
                if (!r_fb && r_ls < r_minv) begin
                    n_state = S_CAND;
                end else if (!w_ord_ok) begin
                    n_state = S_REJECT;
                end else begin
                    n_state = r_fb ? S_WAIT_G0 : S_WAIT_AB;
                end
            S_WAIT_AB:
                if (w_done) begin
                    n_state = w_rem0 ? S_WAIT_G0 : S_REJECT;
                end
            S_WAIT_G0:
                if (w_done) begin
                    n_state = w_rem0 ? S_WAIT_G1 : S_REJECT;
                end
            S_WAIT_G1:
                if (w_done) begin
                    if (!w_rem0) begin
                        n_state = S_REJECT;
                    end else begin
                        n_state = r_three ? S_WAIT_LA : S_FIN;
                    end
                end
            S_REJECT:
                if (r_fb) begin
                    n_state = r_fix ? S_PASS : S_FIN;
                end else begin
                    n_state = S_CAND;
                end
            S_WAIT_LA:
                if (w_done) begin
                    n_state = S_WAIT_MODA;
                end
            S_WAIT_MODA:
                if (w_done && w_rem0) begin
                    n_state = S_FIN;
                end
            S_FIN:
                if (i_take) begin
                    n_state = S_IDLE;
                end
            default:     n_state = S_IDLE;
        endcase
    end

    // datapath and divider requests
    always_comb begin
        n_three = r_three;
        n_ga    = r_ga;
        n_g0    = r_g0;
        n_g1    = r_g1;
        n_fix   = r_fix;
        n_fb    = r_fb;
        n_m     = r_m;
        n_lf    = r_lf;
        n_ls    = r_ls;
        n_maxv  = r_maxv;
        n_minv  = r_minv;
        n_la    = r_la;
        n_lb    = r_lb;
        n_lc    = r_lc;
        n_found = r_found;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = '0;
        o_div_req.divisor  = DIV_W'(1);
        unique case (r_state)
            S_IDLE:
                if (i_start) begin
                    n_three = i_req_type;
                    n_ga    = i_size_a;
                    n_g0    = i_req_type ? i_size_b : i_size_a;
                    n_g1    = i_req_type ? i_size_c : i_size_b;
                    n_fix   = 1'b1;
                    n_m     = (i_cfg.gpu_model >= C_MODEL_DOUBLING) ? {w_cu, 1'b0}
                                                                    : M_W'(w_cu);
                    if (i_cfg.max_group_size == '0) begin
                        n_found = 1'b1;
                        n_la    = LOC_W'(1);
                        n_lb    = LOC_W'(1);
                        n_lc    = LOC_W'(i_req_type);
                    end else begin
                        n_found = 1'b0;
                        n_la    = '0;
                        n_lb    = '0;
                        n_lc    = '0;
                    end
                end
            S_PASS: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = w_gf;
                o_div_req.divisor  = DIV_W'(r_m);
            end
            S_WAIT_M:
                if (w_done) begin
                    if (!w_rem0 || w_lf_new == '0) begin
                        n_fix = 1'b0;
                    end else begin
                        n_lf = w_lf_new;
                        o_div_req.start    = 1'b1;
                        o_div_req.dividend = DIV_W'(i_cfg.max_group_size);
                        o_div_req.divisor  = DIV_W'(w_lf_new);
                    end
                end
            S_WAIT_MAXV:
                if (w_done) begin
                    n_maxv = w_q1;
                    if (i_cfg.subgroup_width != '0) begin
                        o_div_req.start    = 1'b1;
                        o_div_req.dividend = DIV_W'({i_cfg.subgroup_width, 1'b0});
                        o_div_req.divisor  = DIV_W'(r_lf);
                    end else begin
                        n_fb = 1'b1;
                        n_ls = w_fb_ls_new;
                    end
                end
            S_WAIT_MINV:
                if (w_done) begin
                    n_minv = w_q1;
                    n_fb   = 1'b0;
                    n_ls   = (w_gs > DIV_W'(r_maxv)) ? r_maxv : w_gs[LOC_W-1:0];
                end
            S_CAND:
                if (!r_fb && r_ls < r_minv) begin
                    n_fb = 1'b1;
                    n_ls = w_fb_ls;
                end else if (w_ord_ok) begin
                    o_div_req.start = 1'b1;
                    if (r_fb) begin
                        o_div_req.dividend = r_g0;
                        o_div_req.divisor  = DIV_W'(w_a);
                    end else begin
                        o_div_req.dividend = DIV_W'(w_prod);
                        o_div_req.divisor  = DIV_W'(i_cfg.subgroup_width);
                    end
                end
            S_WAIT_AB:
                if (w_done && w_rem0) begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = r_g0;
                    o_div_req.divisor  = DIV_W'(w_a);
                end
            S_WAIT_G0:
                if (w_done && w_rem0) begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = r_g1;
                    o_div_req.divisor  = DIV_W'(w_b);
                end
            S_WAIT_G1:
                if (w_done && w_rem0) begin
                    n_found = 1'b1;
                    if (r_three) begin
                        n_lb = w_a;
                        n_lc = w_b;
                        o_div_req.start    = 1'b1;
                        o_div_req.dividend = DIV_W'(i_cfg.max_group_size);
                        o_div_req.divisor  = DIV_W'(w_prod);
                    end else begin
                        n_la = w_a;
                        n_lb = w_b;
                    end
                end
            S_REJECT:
                if (r_fb) begin
                    n_fix = 1'b0;
                end else begin
                    n_ls = r_ls - 1'b1;
                end
            S_WAIT_LA:
                if (w_done) begin
                    n_la = w_q1;
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = r_ga;
                    o_div_req.divisor  = DIV_W'(w_q1);
                end
            S_WAIT_MODA:
                if (w_done && !w_rem0) begin
                    n_la = r_la - 1'b1;
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = r_ga;
                    o_div_req.divisor  = DIV_W'(r_la - 1'b1);
                end
            S_FIN: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_three <= n_three;
        r_ga    <= n_ga;
        r_g0    <= n_g0;
        r_g1    <= n_g1;
        r_fix   <= n_fix;
        r_fb    <= n_fb;
        r_m     <= n_m;
        r_lf    <= n_lf;
        r_ls    <= n_ls;
        r_maxv  <= n_maxv;
        r_minv  <= n_minv;
        r_la    <= n_la;
        r_lb    <= n_lb;
        r_lc    <= n_lc;
        r_found <= n_found;
    end

    assign o_idle    = (r_state == S_IDLE);
    assign o_fin     = (r_state == S_FIN);
    assign o_found   = r_found;
    assign o_local_a = r_la;
    assign o_local_b = r_lb;
    assign o_local_c = r_lc;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the work-group local size selector.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wlss_pkg::*;

    // Generous ceiling: it covers every request at the slow search of the
    // largest group size that the bench writes, several times over.
    localparam int unsigned CYCLE_LIMIT = 150_000_000;
    localparam int unsigned LONG_HOLD   = 2000;

    typedef struct packed {
        logic             found;
        logic [LOC_W-1:0] la;
        logic [LOC_W-1:0] lb;
        logic [LOC_W-1:0] lc;
    } t_local;

    // One directed row: either a register write or a request transaction,
    // optionally with a hand-typed expected result.
    typedef struct packed {
        logic             is_cfg;
        t_cfg_reg         reg_sel;
        logic [LOC_W-1:0] cfg_val;
        logic             three;
        logic [DIV_W-1:0] ga;
        logic [DIV_W-1:0] gb;
        logic [DIV_W-1:0] gc;
        logic             typed;
        t_local           want;
    } t_row;

    localparam t_local NONE  = '{1'b0, 11'd0, 11'd0, 11'd0};
    localparam t_local ONES2 = '{1'b1, 11'd1, 11'd1, 11'd0};
    localparam t_local ONES3 = '{1'b1, 11'd1, 11'd1, 11'd1};

    localparam int N_ROWS = 29;
    localparam t_row DIRECTED [N_ROWS] = '{
        // reset settings
        '{1'b0, CFG_CU_COUNT,       11'd0,    1'b0, 24'd256, 24'd256, 24'd0, 1'b0, NONE},
        '{1'b0, CFG_CU_COUNT,       11'd0,    1'b1, 24'd64, 24'd64, 24'd64, 1'b0, NONE},
        // unknown group size: all ones
        '{1'b1, CFG_MAX_GROUP_SIZE, 11'd0,    1'b0, 24'd0, 24'd0, 24'd0, 1'b0, NONE},
        '{1'b0, CFG_CU_COUNT,       11'd0,    1'b0, 24'hFFFFFF, 24'd1, 24'd0, 1'b1, ONES2},
        '{1'b0, CFG_CU_COUNT,       11'd0,    1'b1, 24'd0, 24'hFFFFFF, 24'd1, 1'b1, ONES3},
        // nothing divisible by three units: empty results
        '{1'b1, CFG_MAX_GROUP_SIZE, 11'd1024, 1'b0, 24'd0, 24'd0, 24'd0, 1'b0, NONE},
        '{1'b1, CFG_CU_COUNT,       11'd3,    1'b0, 24'd0, 24'd0, 24'd0, 1'b0, NONE},
        '{1'b0, CFG_CU_COUNT,       11'd0,    1'b0, 24'd1, 24'd1, 24'd0, 1'b1, NONE},
        '{1'b0, CFG_CU_COUNT,       11'd0,    1'b1, 24'd4, 24'd1, 24'd2, 1'b1, NONE},
        // zero units read as one, subgroup width 128
        '{1'b1, CFG_CU_COUNT,       11'd0,    1'b0, 24'd0, 24'd0, 24'd0, 1'b0, NONE},
        '{1'b1, CFG_SUBGROUP_WIDTH, 11'd128,  1'b0, 24'd0, 24'd0, 24'd0, 1'b0, NONE},
        '{1'b0, CFG_CU_COUNT,       11'd0,    1'b0, 24'd1024, 24'd2048, 24'd0, 1'b0, NONE},
        '{1'b0, CFG_CU_COUNT,       11'd0,    1'b1, 24'd0, 24'd256, 24'd512, 1'b0, NONE},
        '{1'b0, CFG_CU_COUNT,       11'd0,    1'b0, 24'd0, 24'd64, 24'd0, 1'b0, NONE},
        '{1'b0, CFG_CU_COUNT,       11'd0,    1'b0, 24'd64, 24'd0, 24'd0, 1'b0, NONE},
        // model doubling, unit count of 256
        '{1'b1, CFG_GPU_MODEL,      11'd540,  1'b0, 24'd0, 24'd0, 24'd0, 1'b0, NONE},
        '{1'b1, CFG_CU_COUNT,       11'd256,  1'b0, 24'd0, 24'd0, 24'd0, 1'b0, NONE},
        '{1'b0, CFG_CU_COUNT,       11'd0,    1'b0, 24'd512, 24'd1024, 24'd0, 1'b0, NONE},
        '{1'b1, CFG_SUBGROUP_WIDTH, 11'd1,    1'b0, 24'd0, 24'd0, 24'd0, 1'b0, NONE},
        '{1'b1, CFG_MAX_GROUP_SIZE, 11'd1,    1'b0, 24'd0, 24'd0, 24'd0, 1'b0, NONE},
        '{1'b0, CFG_CU_COUNT,       11'd0,    1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
          1'b0, NONE},
        '{1'b1, CFG_GPU_MODEL,      11'd1023, 1'b0, 24'd0, 24'd0, 24'd0, 1'b0, NONE},
        '{1'b0, CFG_CU_COUNT,       11'd0,    1'b0, 24'd12, 24'd36, 24'd0, 1'b0, NONE},
        '{1'b1, CFG_SUBGROUP_WIDTH, 11'd32,   1'b0, 24'd0, 24'd0, 24'd0, 1'b0, NONE},
        '{1'b1, CFG_MAX_GROUP_SIZE, 11'd64,   1'b0, 24'd0, 24'd0, 24'd0, 1'b0, NONE},
        '{1'b1, CFG_GPU_MODEL,      11'd539,  1'b0, 24'd0, 24'd0, 24'd0, 1'b0, NONE},
        '{1'b0, CFG_CU_COUNT,       11'd0,    1'b1, 24'd1000, 24'd96, 24'd64, 1'b0, NONE},
        '{1'b1, CFG_CU_COUNT,       11'd1,    1'b0, 24'd0, 24'd0, 24'd0, 1'b0, NONE},
        '{1'b0, CFG_CU_COUNT,       11'd0,    1'b0, 24'd96, 24'd32, 24'd0, 1'b0, NONE}
    };

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index;
    logic [LOC_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    logic             i_req_type;
    logic [DIV_W-1:0] i_size_a;
    logic [DIV_W-1:0] i_size_b;
    logic [DIV_W-1:0] i_size_c;
    logic             o_out_valid;
    logic             i_out_ready;
    logic             o_found;
    logic [LOC_W-1:0] o_local_a;
    logic [LOC_W-1:0] o_local_b;
    logic [LOC_W-1:0] o_local_c;

    // Shadow copy of the register file, updated on each accepted write
    int unsigned cu_q, mgs_q, sgw_q, model_q;

    t_local      pending_q[$];
    int unsigned n_errors = 0;
    int unsigned cycles = 0;

    // Sender / receiver knobs
    int unsigned burst_left = 0;
    int unsigned max_gap = 12;
    int unsigned stall_mode = 0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned stall_phase = 0;

    workgroup_local_size_select dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Predictor: local size search, held in 32-bit unsigned arithmetic
    // ---------------------------------------------------------------

    // One pass: fix one dimension to its share per group, search the other
    // downward; order of the locals must follow the order of the globals.
    function automatic bit fit_pass(input int unsigned g0, input int unsigned g1,
                                    input bit fix_second, input int unsigned m,
                                    output int unsigned l0, output int unsigned l1);
        int unsigned gf, gs, lf, ls, hi, lo, a, b;
        gf = fix_second ? g1 : g0;
        gs = fix_second ? g0 : g1;
        l0 = 0;
        l1 = 0;
        if (gf % m != 0) return 1'b0;
        lf = (gf / m < mgs_q) ? gf / m : mgs_q;
        if (lf == 0) return 1'b0;
        if (sgw_q != 0) begin
            hi = (mgs_q / lf > 1) ? mgs_q / lf : 1;
            lo = ((sgw_q * 2) / lf > 1) ? (sgw_q * 2) / lf : 1;
            for (ls = (gs < hi) ? gs : hi; ls >= lo; ls--) begin
                a = fix_second ? ls : lf;
                b = fix_second ? lf : ls;
                if ((a * b) % sgw_q == 0 && g0 % a == 0 && g1 % b == 0 &&
                    ((a < b) == (g0 < g1))) begin
                    l0 = a;
                    l1 = b;
                    return 1'b1;
                end
            end
        end
        // single fallback size
        ls = (gs < mgs_q / lf) ? gs : mgs_q / lf;
        if (ls == 0) ls = 1;
        a = fix_second ? ls : lf;
        b = fix_second ? lf : ls;
        if (g0 % a == 0 && g1 % b == 0 && ((a < b) == (g0 < g1))) begin
            l0 = a;
            l1 = b;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int unsigned group_count();
        int unsigned cu;
        cu = (cu_q == 0) ? 1 : cu_q;
        return (model_q >= C_MODEL_DOUBLING) ? 2 * cu : cu;
    endfunction

    function automatic t_local pick_locals(input bit three, input int unsigned ga,
                                           input int unsigned gb, input int unsigned gc);
        t_local      r;
        int unsigned la, lb, lc, g0, g1, m;
        bit          ok;
        la = 0;
        lb = 0;
        lc = 0;
        m  = group_count();
        if (mgs_q == 0) begin
            ok = 1'b1;
            la = 1;
            lb = 1;
            lc = three ? 1 : 0;
        end else begin
            g0 = three ? gb : ga;
            g1 = three ? gc : gb;
            ok = fit_pass(g0, g1, 1'b1, m, la, lb);
            if (!ok) ok = fit_pass(g0, g1, 1'b0, m, la, lb);
            if (three) begin
                lc = lb;
                lb = la;
                if (ok) begin
                    la = (mgs_q / (lb * lc) > 1) ? mgs_q / (lb * lc) : 1;
                    while (ga % la != 0) la--;
                end
            end
        end
        if (!ok) begin
            la = 0;
            lb = 0;
            lc = 0;
        end
        r.found = ok;
        r.la    = la[LOC_W-1:0];
        r.lb    = lb[LOC_W-1:0];
        r.lc    = lc[LOC_W-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Register write; valid is dropped for a cycle after each transaction.
    task automatic write_reg(input t_cfg_reg sel, input int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= val[LOC_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (sel)
            CFG_CU_COUNT:       cu_q    = val & 32'h1FF;
            CFG_MAX_GROUP_SIZE: mgs_q   = val & 32'h7FF;
            CFG_SUBGROUP_WIDTH: sgw_q   = val & 32'hFF;
            CFG_GPU_MODEL:      model_q = val & 32'h3FF;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Drain: stop offering, wait for every expected result, then let the
    // sequencer settle before touching the registers.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        burst_left = 0;
    endtask

    // Offer one request transaction in burst/gap fashion. Valid is only
    // lowered in gaps, so back-to-back transactions keep it high.
    task automatic send_req(input bit three, input int unsigned ga, input int unsigned gb,
                            input int unsigned gc, input bit typed, input t_local want);
        if (burst_left == 0) begin
            if (max_gap != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, max_gap)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_req_type <= three;
        i_size_a   <= ga[DIV_W-1:0];
        i_size_b   <= gb[DIV_W-1:0];
        i_size_c   <= gc[DIV_W-1:0];
        do @(posedge i_clk); while (!o_in_ready);
        pending_q.insert(pending_q.size(), typed ? want : pick_locals(three, ga, gb, gc));
    endtask

    // Global size: mostly multiples of the group count so the search gets
    // past its divisibility gate, with some raw 24-bit noise.
    function automatic int unsigned rand_global();
        int unsigned v;
        case ($urandom_range(0, 9))
            0, 1:    v = $urandom & 32'hFFFFFF;
            2:       v = $urandom_range(1, 16);
            default: v = group_count() * (1 << $urandom_range(0, 8)) * $urandom_range(1, 3);
        endcase
        v &= 32'hFFFFFF;
        return (v == 0) ? 1 : v;
    endfunction

    // ---------------------------------------------------------------
    // Receiver: own stall pattern plus one long hold-off on request
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_out_ready <= 1'b0;
            hold_left   <= LONG_HOLD;
            hold_done   <= 1'b1;
        end else begin
            case (stall_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(0, 1));
                2:       i_out_ready <= (stall_phase % 3 != 0);
                default: i_out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Result checker: oldest expectation against each result transaction
    always @(posedge i_clk) begin
        t_local want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                $error("result transaction with nothing expected");
                n_errors++;
            end else begin
                want = pending_q.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    n_errors++;
                end
                if (o_local_a !== want.la) begin
                    $error("local_a: expected %0d, got %0d", want.la, o_local_a);
                    n_errors++;
                end
                if (o_local_b !== want.lb) begin
                    $error("local_b: expected %0d, got %0d", want.lb, o_local_b);
                    n_errors++;
                end
                if (o_local_c !== want.lc) begin
                    $error("local_c: expected %0d, got %0d", want.lc, o_local_c);
                    n_errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int unsigned n, mgs_pick;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_CU_COUNT;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_req_type  <= 1'b0;
        i_size_a    <= '0;
        i_size_b    <= '0;
        i_size_c    <= '0;
        cu_q    = 1;
        mgs_q   = 256;
        sgw_q   = 0;
        model_q = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        stall_mode = 1;
        for (int r = 0; r < N_ROWS; r++) begin
            if (DIRECTED[r].is_cfg) begin
                drain();
                write_reg(DIRECTED[r].reg_sel, DIRECTED[r].cfg_val);
            end else begin
                send_req(DIRECTED[r].three, DIRECTED[r].ga, DIRECTED[r].gb,
                         DIRECTED[r].gc, DIRECTED[r].typed, DIRECTED[r].want);
            end
        end

        // Random phases, each under a fresh register setting
        for (int ph = 0; ph < 7; ph++) begin
            drain();
            stall_mode = ph % 4;
            max_gap    = (ph % 3 == 1) ? 0 : $urandom_range(2, 20);
            case ($urandom_range(0, 9))
                0:       mgs_pick = 0;
                1:       mgs_pick = 1024;
                default: mgs_pick = $urandom_range(1, 64);
            endcase
            // the pressure phase: fast results and a long receiver hold-off
            if (ph == 2) begin
                mgs_pick   = 0;
                max_gap    = 0;
                stall_mode = 0;
            end
            write_reg(CFG_CU_COUNT, ($urandom_range(0, 1) != 0) ?
                      $urandom_range(1, 4) : $urandom_range(1, 256));
            write_reg(CFG_MAX_GROUP_SIZE, mgs_pick);
            case ($urandom_range(0, 2))
                0:       write_reg(CFG_SUBGROUP_WIDTH, 0);
                1:       write_reg(CFG_SUBGROUP_WIDTH, 1 << $urandom_range(0, 7));
                default: write_reg(CFG_SUBGROUP_WIDTH, $urandom_range(0, 128));
            endcase
            write_reg(CFG_GPU_MODEL, $urandom_range(0, 1023));
            if (ph == 2) hold_req = 1'b1;
            n = (mgs_pick == 1024) ? 8 : 18;
            for (int k = 0; k < n; k++) begin
                send_req($urandom_range(0, 1), rand_global(), rand_global(),
                         rand_global(), 1'b0, NONE);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
